[rtl/swo_pkg.sv]
// Shared widths, direction codes, stage payload types and saturation helpers for the odometry.
package swo_pkg;

   localparam int unsigned RAW_W    = 31;
   localparam int unsigned ACC_W    = 32;
   localparam int unsigned SCALE_W  = 24;
   localparam int unsigned DIR_W    = 2;
   localparam int unsigned CM_W     = 48;
   localparam int unsigned TRAVEL_W = 47;
   localparam int unsigned PROD_W   = ACC_W + SCALE_W + 1;  // signed pulses x unsigned scale
   localparam int unsigned TPROD_W  = RAW_W + SCALE_W;      // halved raw sum x scale

   // direction command codes, only the sign matters for negative values
   localparam logic [DIR_W-1:0] DIR_KEEP = 2'b00;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;

   localparam logic signed [CM_W-1:0] CM_MAX = {1'b0, {(CM_W-1){1'b1}}};
   localparam logic signed [CM_W-1:0] CM_MIN = {1'b1, {(CM_W-1){1'b0}}};
   localparam logic [TRAVEL_W-1:0]    TRAVEL_MAX = {TRAVEL_W{1'b1}};

   // accumulator snapshot after the state update
   typedef struct packed {
      logic signed [ACC_W-1:0] acc_left;
      logic signed [ACC_W-1:0] acc_right;
      logic [RAW_W-1:0]        half;
   } acc_stage_type;

   // raw products before saturation
   typedef struct packed {
      logic signed [ACC_W-1:0]  acc_left;
      logic signed [ACC_W-1:0]  acc_right;
      logic signed [PROD_W-1:0] left_prod;
      logic signed [PROD_W-1:0] right_prod;
      logic [TPROD_W-1:0]       travel_prod;
   } prod_stage_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] left_pulses;
      logic signed [ACC_W-1:0] right_pulses;
      logic signed [CM_W-1:0]  left_cm;
      logic signed [CM_W-1:0]  right_cm;
      logic signed [CM_W-1:0]  mean_cm;
      logic [TRAVEL_W-1:0]     travel_cm;
   } result_type;

   // clamp a signed product into the 48-bit distance range
   function automatic logic signed [CM_W-1:0] sat_cm(input logic signed [PROD_W-1:0] p);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &p[PROD_W-1:CM_W-1];
      hi_zeros = ~|p[PROD_W-1:CM_W-1];
      if (hi_ones || hi_zeros) begin
         sat_cm = p[CM_W-1:0];
      end else if (p[PROD_W-1]) begin
         sat_cm = CM_MIN;
      end else begin
         sat_cm = CM_MAX;
      end
   endfunction

   function automatic logic [TRAVEL_W-1:0] sat_travel(input logic [TPROD_W-1:0] p);
      if (|p[TPROD_W-1:TRAVEL_W]) begin
         sat_travel = TRAVEL_MAX;
      end else begin
         sat_travel = p[TRAVEL_W-1:0];
      end
   endfunction

endpackage

[rtl/swo_req_if.sv]
// Request channel: raw encoder counts and direction commands with valid/ready.
interface swo_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [swo_pkg::RAW_W-1:0]            left_raw;
   logic [swo_pkg::RAW_W-1:0]            right_raw;
   logic signed [swo_pkg::DIR_W-1:0]     left_dir;
   logic signed [swo_pkg::DIR_W-1:0]     right_dir;

   modport source (output valid, left_raw, right_raw, left_dir, right_dir, input ready);
   modport sink   (input valid, left_raw, right_raw, left_dir, right_dir, output ready);
endinterface

[rtl/swo_rsp_if.sv]
// Response channel: signed pulse counts, signed Q32.16 distances and unsigned Q31.16 travel with valid/ready.
interface swo_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swo_pkg::ACC_W-1:0]     left_pulses;
   logic signed [swo_pkg::ACC_W-1:0]     right_pulses;
   logic signed [swo_pkg::CM_W-1:0]      left_cm;
   logic signed [swo_pkg::CM_W-1:0]      right_cm;
   logic signed [swo_pkg::CM_W-1:0]      mean_cm;
   logic [swo_pkg::TRAVEL_W-1:0]         travel_cm;

   modport source (output valid, left_pulses, right_pulses, left_cm, right_cm, mean_cm,
                   travel_cm, input ready);
   modport sink   (input valid, left_pulses, right_pulses, left_cm, right_cm, mean_cm,
                   travel_cm, output ready);
endinterface

[rtl/signed_wheel_odometry.sv]
// Top level of the signed wheel odometry: scale register and three-stage pipeline.
//
//   channel    dir   handshake        payload
//   req_chan   in    valid/ready      left_raw, right_raw, left_dir, right_dir
//   rsp_chan   out   valid/ready      pulses, left/right/mean cm, travel cm
//   csr        in    csr_we           csr_wdata = cm_per_pulse_q16
//
// One request per cycle sustained while rsp_chan is ready; a response passes through the
// three register stages (state update, multiply, saturate/mean) before it is valid.
// Reset is synchronous: pipeline empty, no base, accumulators zero, both wheels forward,
// scale zero (all distances zero).
// Backpressure on rsp_chan stalls each stage in turn; req_chan.ready drops only when
// all three stages hold requests.
module signed_wheel_odometry (
   input  logic                        clock,
   input  logic                        reset,
   swo_req_if.sink                     req_chan,
   swo_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [swo_pkg::SCALE_W-1:0] csr_wdata
);

   // Q8.16 cm/pulse; the user must write it only while the pipeline is empty, unchecked
   logic [swo_pkg::SCALE_W-1:0] scale_ff;

   swo_pkg::acc_stage_type  a_stage;
   logic                    a_valid;
   logic                    a_ready;
   swo_pkg::prod_stage_type b_stage;
   logic                    b_valid;
   logic                    b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   // Stage A: direction latch, re-base on first request or a count drop, signed
   // accumulation of the per-wheel deltas.
   swo_track u_track (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .a_out   (a_stage),
      .a_valid (a_valid),
      .a_ready (a_ready)
   );

   // Stage B: products of pulses and halved raw sum with the scale.
   swo_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .scale   (scale_ff),
      .a_in    (a_stage),
      .a_valid (a_valid),
      .a_ready (a_ready),
      .b_out   (b_stage),
      .b_valid (b_valid),
      .b_ready (b_ready)
   );

   // Stage C: 48-bit saturation, floor mean of the clamped values, travel clamp.
   swo_sat u_sat (
      .clock   (clock),
      .reset   (reset),
      .b_in    (b_stage),
      .b_valid (b_valid),
      .b_ready (b_ready),
      .rsp     (rsp_chan)
   );

endmodule

[rtl/swo_track.sv]
// Odometry state: direction latch, re-base detect, accumulators, and the first pipe stage.
module swo_track (
   input  logic                   clock,
   input  logic                   reset,
   swo_req_if.sink                req,
   output swo_pkg::acc_stage_type a_out,
   output logic                   a_valid,
   input  logic                   a_ready
);

   logic                           have_base_ff, have_base_in;
   logic [swo_pkg::RAW_W-1:0]      base_left_ff, base_left_in;
   logic [swo_pkg::RAW_W-1:0]      base_right_ff, base_right_in;
   logic signed [swo_pkg::ACC_W-1:0] acc_left_ff, acc_left_in;
   logic signed [swo_pkg::ACC_W-1:0] acc_right_ff, acc_right_in;
   logic                           left_rev_ff, left_rev_in;
   logic                           right_rev_ff, right_rev_in;
   logic                           a_valid_ff, a_valid_in;
   swo_pkg::acc_stage_type         a_ff, a_in;

   logic                           accept;
   logic                           rebase;
   logic [swo_pkg::ACC_W-1:0]      delta_left;
   logic [swo_pkg::ACC_W-1:0]      delta_right;
   logic [swo_pkg::RAW_W:0]        raw_sum;

   assign req.ready = !a_valid_ff || a_ready;
   assign accept    = req.valid && req.ready;
   assign a_valid   = a_valid_ff;
   assign a_out     = a_ff;

   always_comb begin
      // direction: forward code clears, any other nonzero code sets reverse
      if (req.left_dir == swo_pkg::DIR_FWD) begin
         left_rev_in = 1'b0;
      end else if (req.left_dir != swo_pkg::DIR_KEEP) begin
         left_rev_in = 1'b1;
      end else begin
         left_rev_in = left_rev_ff;
      end
      if (req.right_dir == swo_pkg::DIR_FWD) begin
         right_rev_in = 1'b0;
      end else if (req.right_dir != swo_pkg::DIR_KEEP) begin
         right_rev_in = 1'b1;
      end else begin
         right_rev_in = right_rev_ff;
      end

      rebase = !have_base_ff || (req.left_raw < base_left_ff)
               || (req.right_raw < base_right_ff);
      delta_left  = {1'b0, req.left_raw - base_left_ff};
      delta_right = {1'b0, req.right_raw - base_right_ff};

      if (rebase) begin
         acc_left_in  = '0;
         acc_right_in = '0;
      end else begin
         acc_left_in  = left_rev_in ? acc_left_ff - delta_left : acc_left_ff + delta_left;
         acc_right_in = right_rev_in ? acc_right_ff - delta_right
                                     : acc_right_ff + delta_right;
      end

      have_base_in  = 1'b1;
      base_left_in  = req.left_raw;
      base_right_in = req.right_raw;

      raw_sum         = {1'b0, req.left_raw} + {1'b0, req.right_raw};
      a_in.acc_left   = acc_left_in;
      a_in.acc_right  = acc_right_in;
      a_in.half       = raw_sum[swo_pkg::RAW_W:1];

      a_valid_in = accept ? 1'b1 : (a_ready ? 1'b0 : a_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_base_ff  <= 1'b0;
         base_left_ff  <= '0;
         base_right_ff <= '0;
         acc_left_ff   <= '0;
         acc_right_ff  <= '0;
         left_rev_ff   <= 1'b0;
         right_rev_ff  <= 1'b0;
         a_valid_ff    <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (accept) begin
            have_base_ff  <= have_base_in;
            base_left_ff  <= base_left_in;
            base_right_ff <= base_right_in;
            acc_left_ff   <= acc_left_in;
            acc_right_ff  <= acc_right_in;
            left_rev_ff   <= left_rev_in;
            right_rev_ff  <= right_rev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= a_in;
      end
   end

   // first request after reset re-bases and clears both accumulators
   assert property (@(posedge clock) disable iff (reset)
      accept && !have_base_ff |=> acc_left_ff == '0 && acc_right_ff == '0)
      else $error("first request did not clear accumulators");

   // any accepted request leaves a base in place
   assert property (@(posedge clock) disable iff (reset)
      accept |=> have_base_ff)
      else $error("base not marked after request");

   // a stalled snapshot must not be overwritten
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_ready |=> a_valid_ff && $stable(a_ff))
      else $error("stage snapshot lost under stall");

endmodule

[rtl/swo_scale.sv]
// Multiply stage: signed pulses and halved raw sum times the scale register.
module swo_scale (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [swo_pkg::SCALE_W-1:0] scale,
   input  swo_pkg::acc_stage_type    a_in,
   input  logic                      a_valid,
   output logic                      a_ready,
   output swo_pkg::prod_stage_type   b_out,
   output logic                      b_valid,
   input  logic                      b_ready
);

   logic                         b_valid_ff, b_valid_in;
   swo_pkg::prod_stage_type      b_ff, b_in;
   logic signed [swo_pkg::PROD_W-1:0] scale_s;
   logic                         advance;

   assign a_ready = !b_valid_ff || b_ready;
   assign advance = a_valid && a_ready;
   assign b_valid = b_valid_ff;
   assign b_out   = b_ff;

   always_comb begin
      scale_s          = swo_pkg::PROD_W'($signed({1'b0, scale}));
      b_in.acc_left    = a_in.acc_left;
      b_in.acc_right   = a_in.acc_right;
      b_in.left_prod   = swo_pkg::PROD_W'(a_in.acc_left) * scale_s;
      b_in.right_prod  = swo_pkg::PROD_W'(a_in.acc_right) * scale_s;
      b_in.travel_prod = swo_pkg::TPROD_W'(a_in.half) * swo_pkg::TPROD_W'(scale);
      b_valid_in       = advance ? 1'b1 : (b_ready ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ff <= b_in;
      end
   end

endmodule

[rtl/swo_sat.sv]
// Output stage: saturate distances, floor mean, clamp travel, hold the response.
module swo_sat (
   input  logic                    clock,
   input  logic                    reset,
   input  swo_pkg::prod_stage_type b_in,
   input  logic                    b_valid,
   output logic                    b_ready,
   swo_rsp_if.source               rsp
);

   logic                          valid_ff, valid_in;
   swo_pkg::result_type           out_ff, out_in;
   logic signed [swo_pkg::CM_W:0] cm_sum;
   logic                          advance;

   assign b_ready = !valid_ff || rsp.ready;
   assign advance = b_valid && b_ready;

   always_comb begin
      out_in.left_pulses  = b_in.acc_left;
      out_in.right_pulses = b_in.acc_right;
      out_in.left_cm      = swo_pkg::sat_cm(b_in.left_prod);
      out_in.right_cm     = swo_pkg::sat_cm(b_in.right_prod);
      // arithmetic shift of the 49-bit sum gives the floor of the halved sum
      cm_sum              = (swo_pkg::CM_W+1)'(out_in.left_cm)
                            + (swo_pkg::CM_W+1)'(out_in.right_cm);
      out_in.mean_cm      = cm_sum[swo_pkg::CM_W:1];
      out_in.travel_cm    = swo_pkg::sat_travel(b_in.travel_prod);
      valid_in            = advance ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.left_pulses  = out_ff.left_pulses;
   assign rsp.right_pulses = out_ff.right_pulses;
   assign rsp.left_cm      = out_ff.left_cm;
   assign rsp.right_cm     = out_ff.right_cm;
   assign rsp.mean_cm      = out_ff.mean_cm;
   assign rsp.travel_cm    = out_ff.travel_cm;

endmodule
